/* hw/rtl/gbi_pkg.sv */
// Shared types, constants and helper functions of the grid bilinear interpolator.
package gbi_pkg;

  localparam int X_POINTS  = 256;
  localparam int KT_POINTS = 256;
  localparam int XAW       = $clog2(X_POINTS);
  localparam int KAW       = $clog2(KT_POINTS);
  localparam int NAW       = $clog2(X_POINTS * KT_POINTS);
  localparam int WFRAC     = 30;
  localparam int DIV_W     = 41;
  localparam int CNT_W     = 9;

  typedef enum logic [1:0] {
    MODE_LOAD_X    = 2'd0,
    MODE_LOAD_KT   = 2'd1,
    MODE_LOAD_NODE = 2'd2,
    MODE_QUERY     = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STAT_INTERP = 2'd0,
    STAT_EXACT  = 2'd1,
    STAT_RANGE  = 2'd2,
    STAT_LOAD   = 2'd3
  } status_t;

  typedef enum logic {
    CFG_X_USED  = 1'b0,
    CFG_KT_USED = 1'b1
  } cfg_reg_t;

  typedef enum logic [4:0] {
    S_IDLE, S_RD0, S_RD1, S_CHK, S_SP, S_SC, S_BR0, S_BR1, S_BR2, S_NEX,
    S_N0, S_N1, S_N2, S_N3, S_DIVX, S_DIVK, S_BL0, S_BL1, S_BL2, S_BL3,
    S_BL4, S_BL5, S_BL6, S_FIN
  } state_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic [7:0]         x_index;
    logic [7:0]         kt_index;
    logic [39:0]        x_coord;
    logic [31:0]        kt_coord;
    logic signed [31:0] node_value;
  } in_item_t;

  typedef struct packed {
    logic [30:0] result_value;
    logic [1:0]  status;
  } out_item_t;

  // Last used axis index: the register clamped into [2, lim], minus one.
  function automatic logic [31:0] used_last(logic [CNT_W-1:0] r, int lim);
    logic [31:0] n;
    n = 32'(r);
    if (n < 32'd2) n = 32'd2;
    else if (n > 32'(lim)) n = 32'(lim);
    return n - 32'd1;
  endfunction

  // Clamp a signed 16.16 value at zero.
  function automatic logic [30:0] clamp_val(logic signed [31:0] v);
    return v[31] ? 31'd0 : v[30:0];
  endfunction

endpackage

/* hw/rtl/gbi_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module gbi_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata_r
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

/* hw/rtl/gbi_div.sv */
// Restoring divider that forms a 1.30 bracket weight, one quotient bit per cycle.
module gbi_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [gbi_pkg::DIV_W-1:0]  num,
  input  logic signed [gbi_pkg::DIV_W-1:0]  den,
  output logic [gbi_pkg::WFRAC:0]           q,
  output logic                              done
);
  import gbi_pkg::*;

  localparam int CW = $clog2(WFRAC);

  logic             busy_r;
  logic [CW-1:0]    cnt_r;
  logic [DIV_W-1:0] rem_r;
  logic [DIV_W-1:0] den_r;
  logic [WFRAC:0]   q_r;
  logic             done_r;
  logic [DIV_W-1:0] shifted;
  logic             ge;

  assign shifted = {rem_r[DIV_W-2:0], 1'b0};
  assign ge      = shifted >= den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt_r <= CW'(WFRAC - 1);
      rem_r <= num;
      den_r <= den;
      priority if (den <= 0 || num <= 0) begin
        q_r    <= '0;
        done_r <= 1'b1;
      end else if (num >= den) begin
        q_r    <= (WFRAC+1)'(1) << WFRAC;
        done_r <= 1'b1;
      end else begin
        q_r    <= '0;
        busy_r <= 1'b1;
        done_r <= 1'b0;
      end
    end else if (busy_r) begin
      rem_r  <= ge ? shifted - den_r : shifted;
      q_r    <= {q_r[WFRAC-1:0], ge};
      cnt_r  <= cnt_r - 1'b1;
      busy_r <= cnt_r != '0;
      done_r <= cnt_r == '0;
    end else begin
      done_r <= 1'b0;
    end
  end

  assign q    = q_r;
  assign done = done_r;

endmodule

/* hw/rtl/gbi_blend.sv */
// Two-stage linear blend a + round((b - a) * w / 2^30), halves rounded away from zero.
module gbi_blend (
  input  logic                      clk,
  input  logic signed [31:0]        a,
  input  logic signed [31:0]        b,
  input  logic [gbi_pkg::WFRAC:0]   w,
  output logic signed [31:0]        res_r
);
  import gbi_pkg::*;

  logic signed [32:0] d;
  logic [32:0]        m;
  logic [63:0]        prod_r;
  logic               neg_r;
  logic signed [31:0] a_r;
  logic [63:0]        rounded;
  logic [33:0]        qv;
  logic signed [33:0] sum;

  assign d = 33'(b) - 33'(a);
  assign m = d[32] ? 33'(-d) : d;

  assign rounded = prod_r + (64'd1 << (WFRAC - 1));
  assign qv      = 34'(rounded >> WFRAC);
  assign sum     = neg_r ? 34'(a_r) - signed'(qv) : 34'(a_r) + signed'(qv);

  always_ff @(posedge clk) begin
    prod_r <= 64'(m) * 64'(w);
    neg_r  <= d[32];
    a_r    <= a;
    res_r  <= sum[31:0];
  end

endmodule

/* hw/rtl/grid_bilinear_interpolator.sv */
// Top level of the grid bilinear interpolator: sequencer, axis and node memories.
//
// Usage. Items arrive on the in_ channel (in_valid, in_stall, in_data) and one
// result beat per item leaves on the out_ channel (out_valid, out_stall, out_data).
// A beat moves at a rising edge where valid is high and stall is low.
// Modes 0 to 2 load an x axis entry, a kt axis entry or a node value; the store
// happens at the accept edge, the result (value 0, status 3) passes from S_FIN
// into the output register, and the next beat can be taken once the sequencer is
// back in S_IDLE. Mode 3 runs a query through one sequencer: two reads for the
// range check, a lockstep binary search on both axes (up to eight probes at 256
// entries), two bracket reads, four node reads, two divisions of up to 30 steps
// each in one shared restoring divider, and three passes through a two-stage
// blend unit. A query stops early when it falls out of range, lands on an exact
// node or finds flat rows. One item is worked at a time; the memories see a read
// only while no load can write.
// Reset (synchronous, rst_n low) returns the sequencer to idle, drops out_valid
// and sets both used counts to 256; memory contents are not cleared. When the
// receiver stalls, the finished result waits in the output register while the
// next item may already be taken and worked up to its own result.
module grid_bilinear_interpolator (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  gbi_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output gbi_pkg::out_item_t  out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [8:0]          cfg_wdata
);
  import gbi_pkg::*;

  state_t st_r, st_nxt;

  logic [CNT_W-1:0] x_used_r, kt_used_r;
  logic [XAW-1:0]   xlast;
  logic [KAW-1:0]   klast;

  // Query item and working registers.
  logic [39:0]        xc_r;
  logic [31:0]        kc_r;
  logic [39:0]        x0_r, x1_r;
  logic [31:0]        k0_r, k1_r;
  logic [XAW-1:0]     xlo_r, xhi_r, xmid_r, xmid;
  logic [KAW-1:0]     klo_r, khi_r, kmid_r, kmid;
  logic signed [31:0] v00_r, v10_r, v01_r, v11_r, ylo_r, yhi_r;
  logic [WFRAC:0]     wx_r;
  logic [30:0]        res_val_r;
  status_t            res_st_r;
  logic               out_valid_r;
  out_item_t          out_data_r;

  // Memory ports.
  logic           xm_we, km_we, nm_we;
  logic [XAW-1:0] xm_raddr;
  logic [KAW-1:0] km_raddr;
  logic [NAW-1:0] nm_raddr, nm_waddr;
  logic [39:0]    xm_rdata;
  logic [31:0]    km_rdata, nm_rdata;
  logic [XAW-1:0] nx_sel;
  logic [KAW-1:0] nk_sel;

  // Shared arithmetic units.
  logic                    div_start, div_done;
  logic signed [DIV_W-1:0] div_num, div_den;
  logic [WFRAC:0]          div_q;
  logic signed [31:0]      bl_a, bl_b, bl_res;
  logic [WFRAC:0]          bl_w;

  logic accept, out_free, ex_hit1, ex_hit0, ek_hit1, ek_hit0;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign xlast    = XAW'(used_last(x_used_r, X_POINTS));
  assign klast    = KAW'(used_last(kt_used_r, KT_POINTS));
  assign xmid     = XAW'(({1'b0, xlo_r} + {1'b0, xhi_r}) >> 1);
  assign kmid     = KAW'(({1'b0, klo_r} + {1'b0, khi_r}) >> 1);

  // Bracket tests in S_BR2: x1_r/k1_r hold the upper entries, the memories the lower.
  assign ex_hit1 = x1_r == xc_r;
  assign ex_hit0 = xm_rdata == xc_r;
  assign ek_hit1 = k1_r == kc_r;
  assign ek_hit0 = km_rdata == kc_r;

  // Load writes land in the accept cycle.
  assign xm_we    = accept && in_data.mode == MODE_LOAD_X && 32'(in_data.x_index) < X_POINTS;
  assign km_we    = accept && in_data.mode == MODE_LOAD_KT && 32'(in_data.kt_index) < KT_POINTS;
  assign nm_we    = accept && in_data.mode == MODE_LOAD_NODE &&
                    32'(in_data.x_index) < X_POINTS && 32'(in_data.kt_index) < KT_POINTS;
  assign nm_waddr = NAW'(32'(in_data.x_index) * KT_POINTS + 32'(in_data.kt_index));
  assign nm_raddr = NAW'(32'(nx_sel) * KT_POINTS + 32'(nk_sel));

  gbi_ram #(.W(40), .DEPTH(X_POINTS)) u_x_mem (
    .clk(clk), .we(xm_we), .waddr(XAW'(in_data.x_index)), .wdata(in_data.x_coord),
    .raddr(xm_raddr), .rdata_r(xm_rdata)
  );

  gbi_ram #(.W(32), .DEPTH(KT_POINTS)) u_kt_mem (
    .clk(clk), .we(km_we), .waddr(KAW'(in_data.kt_index)), .wdata(in_data.kt_coord),
    .raddr(km_raddr), .rdata_r(km_rdata)
  );

  gbi_ram #(.W(32), .DEPTH(X_POINTS * KT_POINTS)) u_node_mem (
    .clk(clk), .we(nm_we), .waddr(nm_waddr), .wdata(in_data.node_value),
    .raddr(nm_raddr), .rdata_r(nm_rdata)
  );

  gbi_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
    .q(div_q), .done(div_done)
  );

  gbi_blend u_blend (
    .clk(clk), .a(bl_a), .b(bl_b), .w(bl_w), .res_r(bl_res)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_used_r  <= CNT_W'(256);
      kt_used_r <= CNT_W'(256);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_X_USED:  x_used_r  <= cfg_wdata;
        CFG_KT_USED: kt_used_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // Next state, memory addresses and unit operands.
  always_comb begin
    st_nxt    = st_r;
    in_stall  = st_r != S_IDLE;
    xm_raddr  = '0;
    km_raddr  = '0;
    nx_sel    = xlo_r - 1'b1;
    nk_sel    = klo_r - 1'b1;
    div_start = 1'b0;
    div_num   = DIV_W'(xc_r) - DIV_W'(x0_r);
    div_den   = DIV_W'(x1_r) - DIV_W'(x0_r);
    bl_a      = v00_r;
    bl_b      = v10_r;
    bl_w      = wx_r;
    unique case (st_r)
      S_IDLE: begin
        if (in_valid) st_nxt = (in_data.mode == MODE_QUERY) ? S_RD0 : S_FIN;
      end
      S_RD0: st_nxt = S_RD1;
      S_RD1: begin
        xm_raddr = xlast;
        km_raddr = klast;
        st_nxt   = S_CHK;
      end
      S_CHK: begin
        if (xc_r < x0_r || xc_r > xm_rdata || kc_r < k0_r || kc_r > km_rdata) begin
          st_nxt = S_FIN;
        end else begin
          st_nxt = S_SP;
        end
      end
      S_SP: begin
        xm_raddr = xmid;
        km_raddr = kmid;
        st_nxt   = (xlo_r < xhi_r || klo_r < khi_r) ? S_SC : S_BR0;
      end
      S_SC: st_nxt = S_SP;
      S_BR0: begin
        xm_raddr = xlo_r;
        km_raddr = klo_r;
        st_nxt   = S_BR1;
      end
      S_BR1: begin
        xm_raddr = xlo_r - 1'b1;
        km_raddr = klo_r - 1'b1;
        st_nxt   = S_BR2;
      end
      S_BR2: begin
        if ((ex_hit1 || ex_hit0) && (ek_hit1 || ek_hit0)) begin
          nx_sel = ex_hit1 ? xlo_r : xlo_r - 1'b1;
          nk_sel = ek_hit1 ? klo_r : klo_r - 1'b1;
          st_nxt = S_NEX;
        end else begin
          st_nxt = S_N0;
        end
      end
      S_NEX: st_nxt = S_FIN;
      S_N0: begin
        nx_sel = xlo_r;
        st_nxt = S_N1;
      end
      S_N1: begin
        nk_sel = klo_r;
        st_nxt = S_N2;
      end
      S_N2: begin
        nx_sel = xlo_r;
        nk_sel = klo_r;
        st_nxt = S_N3;
      end
      S_N3: begin
        if (v00_r == v10_r && v01_r == signed'(nm_rdata)) begin
          st_nxt = S_FIN;
        end else begin
          div_start = 1'b1;
          st_nxt    = S_DIVX;
        end
      end
      S_DIVX: begin
        div_num = DIV_W'(kc_r) - DIV_W'(k0_r);
        div_den = DIV_W'(k1_r) - DIV_W'(k0_r);
        if (div_done) begin
          div_start = 1'b1;
          st_nxt    = S_DIVK;
        end
      end
      S_DIVK: if (div_done) st_nxt = S_BL0;
      S_BL0: st_nxt = S_BL1;
      S_BL1: begin
        bl_a   = v01_r;
        bl_b   = v11_r;
        st_nxt = S_BL2;
      end
      S_BL2: st_nxt = S_BL3;
      S_BL3: st_nxt = S_BL4;
      S_BL4: begin
        bl_a   = ylo_r;
        bl_b   = yhi_r;
        bl_w   = div_q;
        st_nxt = S_BL5;
      end
      S_BL5: st_nxt = S_BL6;
      S_BL6: st_nxt = S_FIN;
      S_FIN: if (out_free) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  // Working registers of the query.
  always_ff @(posedge clk) begin
    unique case (st_r)
      S_IDLE: begin
        xc_r      <= in_data.x_coord;
        kc_r      <= in_data.kt_coord;
        res_val_r <= '0;
        res_st_r  <= STAT_LOAD;
      end
      S_RD1: begin
        x0_r <= xm_rdata;
        k0_r <= km_rdata;
      end
      S_CHK: begin
        res_st_r <= STAT_RANGE;
        xlo_r    <= XAW'(1);
        xhi_r    <= xlast;
        klo_r    <= KAW'(1);
        khi_r    <= klast;
      end
      S_SP: begin
        xmid_r <= xmid;
        kmid_r <= kmid;
      end
      S_SC: begin
        if (xlo_r < xhi_r) begin
          if (xm_rdata >= xc_r) xhi_r <= xmid_r;
          else xlo_r <= xmid_r + 1'b1;
        end
        if (klo_r < khi_r) begin
          if (km_rdata >= kc_r) khi_r <= kmid_r;
          else klo_r <= kmid_r + 1'b1;
        end
      end
      S_BR1: begin
        x1_r <= xm_rdata;
        k1_r <= km_rdata;
      end
      S_BR2: begin
        x0_r     <= xm_rdata;
        k0_r     <= km_rdata;
        res_st_r <= STAT_INTERP;
      end
      S_NEX: begin
        res_val_r <= clamp_val(nm_rdata);
        res_st_r  <= STAT_EXACT;
      end
      S_N0: v00_r <= nm_rdata;
      S_N1: v10_r <= nm_rdata;
      S_N2: v01_r <= nm_rdata;
      S_N3: v11_r <= nm_rdata;
      S_DIVX: if (div_done) wx_r <= div_q;
      S_BL2: ylo_r <= bl_res;
      S_BL3: yhi_r <= bl_res;
      S_BL6: res_val_r <= clamp_val(bl_res);
      default: ;
    endcase
  end

  // Output register: one result beat per item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (st_r == S_FIN && out_free) begin
      out_valid_r <= 1'b1;
      out_data_r  <= '{result_value: res_val_r, status: res_st_r};
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A finished item with a free output slot becomes a beat and frees the sequencer.
  a_fin_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_FIN && out_free) |=> (out_valid_r && st_r == S_IDLE))
    else $error("finished item did not reach the output register");

  // The search ends with both brackets collapsed inside the used axes.
  a_search_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_BR0) |-> (xlo_r == xhi_r && xlo_r >= XAW'(1) && xlo_r <= xlast &&
                         klo_r == khi_r && klo_r >= KAW'(1) && klo_r <= klast))
    else $error("binary search left its bracket range");

  // The divider reports only while the sequencer waits for it.
  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (st_r == S_DIVX || st_r == S_DIVK))
    else $error("divider finished outside a division step");

endmodule

/* dv/gbi_checker.sv */
// Checker of the grid bilinear interpolator: watches both channels, predicts and compares.
module gbi_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  gbi_pkg::in_item_t   in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  gbi_pkg::out_item_t  out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [8:0]          cfg_wdata,
  output int                  errors,
  output int                  pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import gbi_pkg::*;

  logic [39:0] x_tab [0:255];
  logic [31:0] kt_tab [0:255];
  logic [31:0] node_tab [0:65535];
  logic [8:0]  x_used_reg;
  logic [8:0]  kt_used_reg;
  out_item_t   result_q [$];

  function automatic int used_count(logic [8:0] r);
    if (r < 9'd2) return 2;
    if (r > 9'd256) return 256;
    return int'(r);
  endfunction

  function automatic longint node_at(int xi, int ki);
    return longint'($signed(node_tab[xi * 256 + ki]));
  endfunction

  // Restoring division giving an unsigned 1.30 fraction, saturated to [0, 1].
  function automatic longint unsigned frac_weight(longint num, longint den);
    longint unsigned rem, q;
    if (den <= 0 || num <= 0) return 64'd0;
    if (num >= den) return 64'd1 << 30;
    rem = longint'(num);
    q = 64'd0;
    for (int i = 0; i < 30; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= longint'(den)) begin
        rem = rem - longint'(den);
        q = q | 64'd1;
      end
    end
    return q;
  endfunction

  // Linear step from a toward b by weight w, halves rounded away from zero.
  function automatic longint lerp_step(longint a, longint b, longint unsigned w);
    longint d;
    longint unsigned m, q;
    d = b - a;
    m = (d < 0) ? longint'(-d) : longint'(d);
    q = (m * w + (64'd1 << 29)) >> 30;
    return (d < 0) ? a - longint'(q) : a + longint'(q);
  endfunction

  function automatic logic [30:0] clamp_pos(longint v);
    if (v < 0) return 31'd0;
    if (v > 64'sh7FFFFFFF) return 31'h7FFFFFFF;
    return v[30:0];
  endfunction

  function automatic out_item_t predict_result(in_item_t it);
    out_item_t res;
    int nx, nk, ix, ik, lo, hi, mid, exi, eki;
    bit ex, ek;
    longint v00, v10, v01, v11, ylo, yhi;
    longint unsigned wx, wk;
    res = '0;
    res.status = STAT_LOAD;
    case (mode_t'(it.mode))
      MODE_LOAD_X:    x_tab[it.x_index] = it.x_coord;
      MODE_LOAD_KT:   kt_tab[it.kt_index] = it.kt_coord;
      MODE_LOAD_NODE: node_tab[int'(it.x_index) * 256 + int'(it.kt_index)] = it.node_value;
      default: begin
        nx = used_count(x_used_reg);
        nk = used_count(kt_used_reg);
        if (it.x_coord < x_tab[0] || it.x_coord > x_tab[nx-1] ||
            it.kt_coord < kt_tab[0] || it.kt_coord > kt_tab[nk-1]) begin
          res.status = STAT_RANGE;
          return res;
        end
        lo = 1;
        hi = nx - 1;
        while (lo < hi) begin
          mid = (lo + hi) / 2;
          if (x_tab[mid] >= it.x_coord) hi = mid; else lo = mid + 1;
        end
        ix = lo;
        lo = 1;
        hi = nk - 1;
        while (lo < hi) begin
          mid = (lo + hi) / 2;
          if (kt_tab[mid] >= it.kt_coord) hi = mid; else lo = mid + 1;
        end
        ik = lo;
        exi = ix;
        eki = ik;
        ex = 1'b1;
        ek = 1'b1;
        if (x_tab[ix] != it.x_coord) begin
          if (x_tab[ix-1] == it.x_coord) exi = ix - 1; else ex = 1'b0;
        end
        if (kt_tab[ik] != it.kt_coord) begin
          if (kt_tab[ik-1] == it.kt_coord) eki = ik - 1; else ek = 1'b0;
        end
        if (ex && ek) begin
          res.status = STAT_EXACT;
          res.result_value = clamp_pos(node_at(exi, eki));
          return res;
        end
        res.status = STAT_INTERP;
        v00 = node_at(ix - 1, ik - 1);
        v10 = node_at(ix, ik - 1);
        v01 = node_at(ix - 1, ik);
        v11 = node_at(ix, ik);
        if (v00 == v10 && v01 == v11) return res;
        wx = frac_weight(longint'(it.x_coord) - longint'(x_tab[ix-1]),
                         longint'(x_tab[ix]) - longint'(x_tab[ix-1]));
        wk = frac_weight(longint'(it.kt_coord) - longint'(kt_tab[ik-1]),
                         longint'(kt_tab[ik]) - longint'(kt_tab[ik-1]));
        ylo = lerp_step(v00, v10, wx);
        yhi = lerp_step(v01, v11, wx);
        res.result_value = clamp_pos(lerp_step(ylo, yhi, wk));
      end
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    int fails;
    out_item_t want;
    fails = 0;
    if (!rst_n) begin
      x_used_reg = 9'd256;
      kt_used_reg = 9'd256;
      result_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_reg_t'(cfg_index) == CFG_X_USED) x_used_reg = cfg_wdata;
        else kt_used_reg = cfg_wdata;
      end
      if (in_valid && !in_stall) result_q.insert(result_q.size(), predict_result(in_data));
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          $display("%0t: result beat with nothing expected: value %h status %0d",
                   $time, out_data.result_value, out_data.status);
          fails++;
        end else begin
          want = result_q.pop_front();
          if (out_data.result_value !== want.result_value) begin
            $display("%0t: result_value mismatch: expected %h actual %h",
                     $time, want.result_value, out_data.result_value);
            fails++;
          end
          if (out_data.status !== want.status) begin
            $display("%0t: status mismatch: expected %0d actual %0d",
                     $time, want.status, out_data.status);
            fails++;
          end
        end
      end
    end
    errors <= errors + fails;
    pending <= result_q.size();
  end

endmodule

/* dv/tb_top.sv */
// Testbench top of the grid bilinear interpolator: stimulus, idling and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import gbi_pkg::*;

  localparam int TOTAL_ITEMS = 1050;
  localparam int QUIET_TAIL  = 120;
  localparam int HOLD_CYCLES = 300;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  in_item_t   in_data;
  logic       out_valid;
  logic       out_stall;
  out_item_t  out_data;
  logic       cfg_we;
  logic       cfg_index;
  logic [8:0] cfg_wdata;
  int         errors;
  int         pending;

  // Mirror of the loaded axes, used only to aim queries at useful coordinates.
  logic [39:0] x_seen [0:255];
  logic [31:0] kt_seen [0:255];
  int          nx_eff, nk_eff;
  int          items_sent;
  bit          quiet;
  bit          hold_req;

  always #2 clk = ~clk;

  grid_bilinear_interpolator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  gbi_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .errors(errors), .pending(pending)
  );

  // The receiver stalls in short random bursts, and once holds off for a long
  // stretch so that the block fills up and pushes back on its input.
  initial begin
    bit held;
    held = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && rst_n && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic logic [39:0] rnd40();
    logic [63:0] t;
    t = {$urandom, $urandom};
    return t[39:0];
  endfunction

  function automatic longint unsigned pick(longint unsigned lo, longint unsigned hi);
    longint unsigned t;
    t = {$urandom, $urandom};
    return lo + t % (hi - lo + 1);
  endfunction

  // Every field but the mode starts out random, so unused fields still toggle all their bits.
  function automatic in_item_t rnd_item(mode_t m);
    in_item_t it;
    it.mode = m;
    it.x_index = 8'($urandom);
    it.kt_index = 8'($urandom);
    it.x_coord = rnd40();
    it.kt_coord = $urandom;
    it.node_value = $urandom;
    return it;
  endfunction

  // Offer one beat and hold it until taken; valid stays high for the next one.
  task automatic send(in_item_t it);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (items_sent >= TOTAL_ITEMS - QUIET_TAIL) quiet = 1'b1;
    if (items_sent > 700) hold_req = 1'b1;
  endtask

  task automatic load_x(int i, logic [39:0] v);
    in_item_t it;
    it = rnd_item(MODE_LOAD_X);
    it.x_index = 8'(i);
    it.x_coord = v;
    x_seen[i] = v;
    send(it);
  endtask

  task automatic load_kt(int i, logic [31:0] v);
    in_item_t it;
    it = rnd_item(MODE_LOAD_KT);
    it.kt_index = 8'(i);
    it.kt_coord = v;
    kt_seen[i] = v;
    send(it);
  endtask

  task automatic load_node(int xi, int ki, logic [31:0] v);
    in_item_t it;
    it = rnd_item(MODE_LOAD_NODE);
    it.x_index = 8'(xi);
    it.kt_index = 8'(ki);
    it.node_value = v;
    send(it);
  endtask

  task automatic query(logic [39:0] xc, logic [31:0] kc);
    in_item_t it;
    it = rnd_item(MODE_QUERY);
    it.x_coord = xc;
    it.kt_coord = kc;
    send(it);
  endtask

  // Registers change only with the block idle: no beat in flight, no result owed.
  task automatic set_cfg(cfg_reg_t r, logic [8:0] v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [39:0] x_inside();
    if (x_seen[nx_eff-1] >= x_seen[0]) return 40'(pick(x_seen[0], x_seen[nx_eff-1]));
    return rnd40();
  endfunction

  function automatic logic [31:0] kt_inside();
    if (kt_seen[nk_eff-1] >= kt_seen[0]) return 32'(pick(kt_seen[0], kt_seen[nk_eff-1]));
    return $urandom;
  endfunction

  // Node values are mostly random, sometimes copied from the left neighbor so
  // that flat rows occur, and sometimes the signed extremes.
  function automatic logic [31:0] node_pick(int xi, int ki, logic [31:0] left);
    case ($urandom_range(0, 15))
      0, 1, 2: return (xi > 0) ? left : $urandom;
      3:       return 32'h7FFF_FFFF;
      4:       return 32'h8000_0000;
      5, 6:    return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
      default: return $urandom;
    endcase
  endfunction

  // One phase with a small lattice: set both used counts, reload the axes
  // (usually sorted, sometimes with repeats or out of order), fill every node
  // the queries can touch, then mix queries with stray loads.
  task automatic small_phase();
    logic [8:0]  xr, kr;
    logic [39:0] xv;
    logic [31:0] kv, left;
    int          step_kind;
    xr = ($urandom_range(0, 5) == 0) ? 9'($urandom_range(0, 2)) : 9'($urandom_range(2, 6));
    kr = ($urandom_range(0, 5) == 0) ? 9'($urandom_range(0, 2)) : 9'($urandom_range(2, 6));
    set_cfg(CFG_X_USED, xr);
    set_cfg(CFG_KT_USED, kr);
    nx_eff = (xr < 2) ? 2 : int'(xr);
    nk_eff = (kr < 2) ? 2 : int'(kr);
    step_kind = $urandom_range(0, 4);
    xv = rnd40() >> 2;
    for (int i = 0; i < nx_eff; i++) begin
      load_x(i, xv);
      if (step_kind == 0) xv = rnd40();
      else if ($urandom_range(0, 7) == 0) xv = xv;
      else xv = xv + $urandom_range(1, 32'h3FFF_FFFF);
    end
    kv = $urandom >> 2;
    for (int i = 0; i < nk_eff; i++) begin
      load_kt(i, kv);
      if (step_kind == 1) kv = $urandom;
      else if ($urandom_range(0, 7) == 0) kv = kv;
      else kv = kv + $urandom_range(1, 32'h00FF_FFFF);
    end
    for (int ki = 0; ki < nk_eff; ki++) begin
      left = $urandom;
      for (int xi = 0; xi < nx_eff; xi++) begin
        left = node_pick(xi, ki, left);
        load_node(xi, ki, left);
      end
    end
    repeat (40) begin
      case ($urandom_range(0, 19))
        0, 1:    query(rnd40(), $urandom);
        2:       query(40'hFF_FFFF_FFFF, 32'hFFFF_FFFF);
        3:       query(40'd0, kt_inside());
        4, 5:    query(x_seen[$urandom_range(0, nx_eff - 1)],
                       kt_seen[$urandom_range(0, nk_eff - 1)]);
        6:       query(x_seen[0], kt_inside());
        7:       query(x_inside(), kt_seen[0]);
        8:       load_node($urandom_range(nx_eff, 255), $urandom_range(0, 255), $urandom);
        9:       load_x($urandom_range(nx_eff, 255), rnd40());
        10:      load_kt($urandom_range(nk_eff, 255), $urandom);
        default: query(x_inside(), kt_inside());
      endcase
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_X_USED;
    cfg_wdata = '0;
    items_sent = 0;
    quiet = 1'b0;
    hold_req = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Full lattice first: both counts above the axis size clamp to 256, and the
    // axes span each coordinate field from zero to its largest value.
    set_cfg(CFG_X_USED, 9'h1FF);
    set_cfg(CFG_KT_USED, 9'h1FF);
    nx_eff = 256;
    nk_eff = 256;
    for (int i = 0; i < 256; i++) begin
      if (i == 0) load_x(i, 40'd0);
      else if (i == 255) load_x(i, 40'hFF_FFFF_FFFF);
      else load_x(i, 40'(longint'(i) * 64'd4311810305 + $urandom_range(0, 999_999)));
    end
    for (int i = 0; i < 256; i++) begin
      if (i == 0) load_kt(i, 32'd0);
      else if (i == 255) load_kt(i, 32'hFFFF_FFFF);
      else load_kt(i, 32'(i * 16843009 + $urandom_range(0, 999)));
    end
    // Only the low corner of the lattice is filled, and queries stay inside it.
    for (int xi = 0; xi < 4; xi++)
      for (int ki = 0; ki < 4; ki++) begin
        if (xi == 0 && ki == 0) load_node(xi, ki, 32'h7FFF_FFFF);
        else if (xi == 1 && ki == 1) load_node(xi, ki, 32'h8000_0000);
        else if (xi == 3 && ki >= 2) load_node(xi, ki, 32'h0003_0000 + ki);
        else if (xi == 2 && ki >= 2) load_node(xi, ki, 32'h0003_0000 + ki);
        else load_node(xi, ki, $urandom);
      end

    // Directed queries: exact nodes at both signed extremes, the first axis entry,
    // plain interpolation, and a cell whose two rows are flat in x.
    query(x_seen[0], kt_seen[0]);
    query(x_seen[1], kt_seen[1]);
    query(x_seen[2], kt_seen[1]);
    query(x_seen[0], (kt_seen[0] + kt_seen[1]) / 2);
    query((x_seen[0] + x_seen[1]) / 2, kt_seen[0]);
    query((x_seen[0] + x_seen[1]) / 2, (kt_seen[0] + kt_seen[1]) / 2);
    query((x_seen[1] + x_seen[2]) / 2, (kt_seen[1] + kt_seen[2]) / 2);
    query((x_seen[2] + x_seen[3]) / 2, (kt_seen[2] + kt_seen[3]) / 2);
    query(x_seen[3], (kt_seen[2] + kt_seen[3]) / 2);
    query(x_seen[3] - 1, kt_seen[3] - 1);
    query(x_seen[1] + 1, kt_seen[1] + 1);

    while (items_sent < TOTAL_ITEMS) small_phase();

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
